// ===== design/fbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbsc_pkg
// Types and constants shared by the frustum box/sphere cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsc_pkg;

  localparam int PLANE_REGS  = 6;
  localparam int REG_IDX_W   = 3;
  localparam int REG_DATA_W  = 64;
  localparam int ALIGN_SHIFT = 14;
  localparam int PROD_W      = 32;
  localparam int PAIR_W      = PROD_W + 1;
  localparam int SUM_W       = PAIR_W + 1;

  typedef logic signed [15:0] coord_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NEAR   = 3'd0,
    REG_FAR    = 3'd1,
    REG_LEFT   = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_TOP    = 3'd4,
    REG_BOTTOM = 3'd5
  } reg_idx_t;

  // bits 15:0 A, 31:16 B, 47:32 C, 63:48 D
  typedef struct packed {
    coord_t d;
    coord_t c;
    coord_t b;
    coord_t a;
  } plane_t;

  typedef struct packed {
    logic        sphere;
    coord_t      min_x;
    coord_t      min_y;
    coord_t      min_z;
    coord_t      max_x;
    coord_t      max_y;
    coord_t      max_z;
    coord_t      cx;
    coord_t      cy;
    coord_t      cz;
    logic [15:0] rad;
  } vol_t;

  typedef struct packed {
    logic adv;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/fbsc_if.sv =====
// ----------------------------------------------------------------------------
// fbsc_if
// Stream channels of the cull block: bounding volume in, visibility out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbsc_vol_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_min_z;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_max_y;
  logic signed [15:0] box_max_z;
  logic signed [15:0] sphere_center_x;
  logic signed [15:0] sphere_center_y;
  logic signed [15:0] sphere_center_z;
  logic        [15:0] sphere_radius;

  modport source (
    output valid, mode, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z,
           sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, mode, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z,
           sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius,
    output ready
  );
endinterface

interface fbsc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

// ===== design/fbsc_plane_regs.sv =====
// ----------------------------------------------------------------------------
// fbsc_plane_regs
// Six 64-bit plane registers, write only. Out-of-range writes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_plane_regs import fbsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0]  cfg_addr,
  input  wire logic [REG_DATA_W-1:0] cfg_wdata,
  output plane_t                     planes [PLANE_REGS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        planes[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_NEAR:   planes[0] <= plane_t'(cfg_wdata);
        REG_FAR:    planes[1] <= plane_t'(cfg_wdata);
        REG_LEFT:   planes[2] <= plane_t'(cfg_wdata);
        REG_RIGHT:  planes[3] <= plane_t'(cfg_wdata);
        REG_TOP:    planes[4] <= plane_t'(cfg_wdata);
        REG_BOTTOM: planes[5] <= plane_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/fbsc_lane.sv =====
// ----------------------------------------------------------------------------
// fbsc_lane
// One plane test in four stages: point select, multiply, pair add, final
// add and sign. Reject means the volume lies fully outside this plane.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_lane import fbsc_pkg::*; (
  input  wire logic   clk,
  input  wire ctl_t   ctl,
  input  wire vol_t   vol,
  input  wire plane_t plane,
  output logic        reject
);

  coord_t                    s1_x, s1_y, s1_z;
  logic [15:0]               s1_rad;
  logic                      s1_sphere;
  logic signed [PROD_W-1:0]  s2_px, s2_py, s2_pz, s2_bias;
  logic signed [PAIR_W-1:0]  s3_xy, s3_zb;
  logic signed [PROD_W-1:0]  d_bias, r_bias;
  logic signed [SUM_W-1:0]   dist_sum;

  // D and radius moved to the 2^18 product scale
  assign d_bias = $signed({{(PROD_W-16-ALIGN_SHIFT){plane.d[15]}}, plane.d,
                           {ALIGN_SHIFT{1'b0}}});
  assign r_bias = $signed({{(PROD_W-16-ALIGN_SHIFT){1'b0}}, s1_rad,
                           {ALIGN_SHIFT{1'b0}}});
  assign dist_sum = SUM_W'(s3_xy) + SUM_W'(s3_zb);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      // box: corner farthest along the normal
      s1_x      <= vol.sphere ? vol.cx : (plane.a[15] ? vol.min_x : vol.max_x);
      s1_y      <= vol.sphere ? vol.cy : (plane.b[15] ? vol.min_y : vol.max_y);
      s1_z      <= vol.sphere ? vol.cz : (plane.c[15] ? vol.min_z : vol.max_z);
      s1_rad    <= vol.rad;
      s1_sphere <= vol.sphere;

      s2_px     <= plane.a * s1_x;
      s2_py     <= plane.b * s1_y;
      s2_pz     <= plane.c * s1_z;
      s2_bias   <= s1_sphere ? d_bias + r_bias : d_bias;

      s3_xy     <= PAIR_W'(s2_px) + PAIR_W'(s2_py);
      s3_zb     <= PAIR_W'(s2_pz) + PAIR_W'(s2_bias);

      reject    <= dist_sum[SUM_W-1];
    end
  end

endmodule

`default_nettype wire

// ===== design/frustum_box_sphere_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull
// Culls an axis aligned box or a sphere against up to six frustum planes.
//
//   port      dir  beat contents
//   item      in   mode, box corners, sphere center and radius (Q12.4)
//   result    out  visible
//   cfg_*     in   plane register write, index 0..5, 64-bit data
//
// One beat per cycle while the output is not stalled; 4 lane stages + output register.
// Reset clears plane registers and all valid bits.
// The whole pipeline holds while the output beat is not taken; item.ready
// is low only then.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_sphere_cull import fbsc_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  fbsc_vol_if.sink                   item,
  fbsc_vis_if.source                 result,
  input  wire logic                  cfg_wr_en,
  input  wire logic [REG_IDX_W-1:0]  cfg_addr,
  input  wire logic [REG_DATA_W-1:0] cfg_wdata
);

  localparam int LANE_STAGES = 4;

  plane_t                  planes [PLANE_REGS];
  ctl_t                    ctl;
  vol_t                    vol;
  logic [NUM_PLANES-1:0]   rejects;
  logic [LANE_STAGES-1:0]  vld;
  logic                    out_vld;
  logic                    out_vis;
  logic                    adv;

  assign adv         = !out_vld || result.ready;
  assign ctl.adv     = adv;
  assign item.ready  = adv;
  assign result.valid   = out_vld;
  assign result.visible = out_vis;

  assign vol.sphere = item.mode;
  assign vol.min_x  = item.box_min_x;
  assign vol.min_y  = item.box_min_y;
  assign vol.min_z  = item.box_min_z;
  assign vol.max_x  = item.box_max_x;
  assign vol.max_y  = item.box_max_y;
  assign vol.max_z  = item.box_max_z;
  assign vol.cx     = item.sphere_center_x;
  assign vol.cy     = item.sphere_center_y;
  assign vol.cz     = item.sphere_center_z;
  assign vol.rad    = item.sphere_radius;

  fbsc_plane_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .planes    (planes)
  );

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_lane
    fbsc_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .vol    (vol),
      .plane  (planes[k]),
      .reject (rejects[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld     <= {vld[LANE_STAGES-2:0], item.valid};
      out_vld <= vld[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vis <= ~|rejects;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !item.ready)
    else $error("input taken while output beat is stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> vld[0])
    else $error("accepted beat missing from first stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid && vld == '0)
    else $error("pipeline not empty after reset");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    vld[LANE_STAGES-1] && adv |=> out_vld)
    else $error("beat lost between last stage and output");

endmodule

`default_nettype wire

// ===== verif/cull_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cull_checker
// Watches the volume and visibility channels and the plane write port of the
// frustum cull block. Keeps its own copy of the six planes, works out the
// visibility of every accepted volume, and compares each result beat, in
// order, against the oldest prediction still due.
// ----------------------------------------------------------------------------
module cull_checker import fbsc_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  fbsc_vol_if                   item,
  fbsc_vis_if                   result,
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_addr,
  input  logic [REG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  plane_t planes [PLANE_REGS];
  bit     visibility_due [$];
  int     fail_count = 0;
  int     due_count  = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] cull mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // exact distance at scale 2^18; D is lifted by 2^14 to line up with A*x
  function automatic longint plane_distance(plane_t p, coord_t x, coord_t y, coord_t z);
    return longint'(p.a) * longint'(x) + longint'(p.b) * longint'(y) +
           longint'(p.c) * longint'(z) + (longint'(p.d) <<< ALIGN_SHIFT);
  endfunction

  function automatic bit predict_visible(vol_t v);
    bit     vis = 1'b1;
    plane_t p;
    longint dist_val;
    longint floor_dist;
    for (int i = 0; i < NUM_PLANES; i++) begin
      p = planes[i];
      if (v.sphere) begin
        dist_val   = plane_distance(p, v.cx, v.cy, v.cz);
        floor_dist = -(longint'(v.rad) <<< ALIGN_SHIFT);
        if (dist_val < floor_dist) vis = 1'b0;
      end else begin
        // farthest corner along the normal, no swap for inverted boxes
        dist_val = plane_distance(p, (p.a >= 0) ? v.max_x : v.min_x,
                                     (p.b >= 0) ? v.max_y : v.min_y,
                                     (p.c >= 0) ? v.max_z : v.min_z);
        if (dist_val < 0) vis = 1'b0;
      end
    end
    return vis;
  endfunction

  always @(posedge clk) begin
    vol_t v;
    bit   want;
    if (rst) begin
      for (int i = 0; i < PLANE_REGS; i++) planes[i] = '0;
      visibility_due.delete();
    end else begin
      if (cfg_wr_en && cfg_addr < PLANE_REGS) planes[cfg_addr] = cfg_wdata;
      if (item.valid && item.ready) begin
        v.sphere = item.mode;
        v.min_x  = item.box_min_x;
        v.min_y  = item.box_min_y;
        v.min_z  = item.box_min_z;
        v.max_x  = item.box_max_x;
        v.max_y  = item.box_max_y;
        v.max_z  = item.box_max_z;
        v.cx     = item.sphere_center_x;
        v.cy     = item.sphere_center_y;
        v.cz     = item.sphere_center_z;
        v.rad    = item.sphere_radius;
        visibility_due.push_back(predict_visible(v));
      end
      if (result.valid && result.ready) begin
        if (visibility_due.size() == 0) begin
          report_mismatch($sformatf("result beat visible=%b with nothing due", result.visible));
        end else begin
          want = visibility_due.pop_front();
          if (result.visible !== want)
            report_mismatch($sformatf("visible=%b, predicted %b", result.visible, want));
        end
      end
    end
    due_count = visibility_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the frustum cull block. Programs plane sets through the write
// port while the pipeline is empty, sends directed boxes and spheres on the
// plane boundaries and the field extremes, then random volumes under several
// plane sets (zero, extreme, normalized, raw). Both channels idle in random
// bursts; one phase holds the result side off long enough to back up the
// pipeline. The checker does all comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import fbsc_pkg::*;

  localparam int NUM_PLANES      = 6;
  localparam int LATENCY         = 5;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 163;
  localparam int PRESSURE_PHASE  = 6;
  localparam int HOLD_CYCLES     = 64;
  localparam int IDLE_LIMIT      = 2000;

  localparam logic [REG_IDX_W-1:0] UNUSED_IDX_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] UNUSED_IDX_HI = 3'd7;

  localparam coord_t ONE_Q14     = 16'sd16384;
  localparam coord_t NEG_ONE_Q14 = -16'sd16384;
  localparam coord_t FAR_D       = 16'sd1600;
  localparam coord_t COORD_MAX   = 16'sh7FFF;
  localparam coord_t COORD_MIN   = 16'sh8000;

  typedef enum int {PLANE_ZERO, PLANE_NORMAL, PLANE_RAW} plane_style_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [REG_IDX_W-1:0]  cfg_addr;
  logic [REG_DATA_W-1:0] cfg_wdata;
  int                    errors;
  int                    pending;
  logic                  calm;
  logic                  squeeze;
  logic                  pressure_done;
  int                    stall_left;
  int                    hold_left;
  int                    idle_cycles;

  fbsc_vol_if vol_ch ();
  fbsc_vis_if vis_ch ();

  frustum_box_sphere_cull #(.NUM_PLANES(NUM_PLANES)) dut (
    .clk       (clk),
    .rst       (rst),
    .item      (vol_ch),
    .result    (vis_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  cull_checker #(.NUM_PLANES(NUM_PLANES)) checker_i (
    .clk       (clk),
    .rst       (rst),
    .item      (vol_ch),
    .result    (vis_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stall bursts, one long hold in the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      vis_ch.ready  <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else if (hold_left > 0) begin
      vis_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (squeeze && !pressure_done) begin
      vis_ch.ready  <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else if (stall_left > 0) begin
      vis_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      vis_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 4);
    end else begin
      vis_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (vol_ch.valid && vol_ch.ready) || (vis_ch.valid && vis_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic coord_t rand_coord(bit wide);
    return wide ? coord_t'($urandom) : coord_t'($urandom_range(0, 4000)) - 16'sd2000;
  endfunction

  function automatic vol_t rand_volume();
    vol_t   v;
    bit     wide = ($urandom_range(0, 3) == 0);
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    for (int k = 0; k < 3; k++) begin
      lo[k] = rand_coord(wide);
      hi[k] = rand_coord(wide);
      // mostly ordered boxes, some left inverted
      if (lo[k] > hi[k] && $urandom_range(0, 7) != 0) begin
        t     = lo[k];
        lo[k] = hi[k];
        hi[k] = t;
      end
    end
    v.sphere = 1'($urandom_range(0, 1));
    v.min_x  = lo[0];
    v.min_y  = lo[1];
    v.min_z  = lo[2];
    v.max_x  = hi[0];
    v.max_y  = hi[1];
    v.max_z  = hi[2];
    v.cx     = rand_coord(wide);
    v.cy     = rand_coord(wide);
    v.cz     = rand_coord(wide);
    v.rad    = wide ? 16'($urandom) : 16'($urandom_range(0, 1200));
    return v;
  endfunction

  function automatic vol_t mk_box(coord_t mnx, coord_t mny, coord_t mnz,
                                  coord_t mxx, coord_t mxy, coord_t mxz);
    vol_t v = rand_volume();
    v.sphere = 1'b0;
    v.min_x  = mnx;
    v.min_y  = mny;
    v.min_z  = mnz;
    v.max_x  = mxx;
    v.max_y  = mxy;
    v.max_z  = mxz;
    return v;
  endfunction

  function automatic vol_t mk_sphere(coord_t x, coord_t y, coord_t z, logic [15:0] r);
    vol_t v = rand_volume();
    v.sphere = 1'b1;
    v.cx     = x;
    v.cy     = y;
    v.cz     = z;
    v.rad    = r;
    return v;
  endfunction

  function automatic plane_t rand_plane(plane_style_t style);
    plane_t p;
    case (style)
      PLANE_ZERO: p = '0;
      PLANE_RAW:  p = {$urandom, $urandom};
      default: begin
        p.a = coord_t'($urandom_range(0, 32768)) - ONE_Q14;
        p.b = coord_t'($urandom_range(0, 32768)) - ONE_Q14;
        p.c = coord_t'($urandom_range(0, 32768)) - ONE_Q14;
        p.d = coord_t'($urandom_range(0, 4000)) - 16'sd2000;
      end
    endcase
    return p;
  endfunction

  task automatic send_volume(input vol_t v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      vol_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    vol_ch.valid           <= 1'b1;
    vol_ch.mode            <= v.sphere;
    vol_ch.box_min_x       <= v.min_x;
    vol_ch.box_min_y       <= v.min_y;
    vol_ch.box_min_z       <= v.min_z;
    vol_ch.box_max_x       <= v.max_x;
    vol_ch.box_max_y       <= v.max_y;
    vol_ch.box_max_z       <= v.max_z;
    vol_ch.sphere_center_x <= v.cx;
    vol_ch.sphere_center_y <= v.cy;
    vol_ch.sphere_center_z <= v.cz;
    vol_ch.sphere_radius   <= v.rad;
    @(posedge clk);
    while (!vol_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    vol_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // writes all six planes, plus stray writes to the unused indexes
  task automatic program_frustum(input plane_t pl [PLANE_REGS]);
    for (int i = 0; i < PLANE_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= REG_IDX_W'(i);
      cfg_wdata <= pl[i];
      @(posedge clk);
    end
    cfg_addr  <= UNUSED_IDX_LO;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_addr  <= UNUSED_IDX_HI;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    plane_t frustum [PLANE_REGS];

    rst                    <= 1'b1;
    calm                   <= 1'b0;
    squeeze                <= 1'b0;
    cfg_wr_en              <= 1'b0;
    cfg_addr               <= REG_NEAR;
    cfg_wdata              <= '0;
    vol_ch.valid           <= 1'b0;
    vol_ch.mode            <= 1'b0;
    vol_ch.box_min_x       <= '0;
    vol_ch.box_min_y       <= '0;
    vol_ch.box_min_z       <= '0;
    vol_ch.box_max_x       <= '0;
    vol_ch.box_max_y       <= '0;
    vol_ch.box_max_z       <= '0;
    vol_ch.sphere_center_x <= '0;
    vol_ch.sphere_center_y <= '0;
    vol_ch.sphere_center_z <= '0;
    vol_ch.sphere_radius   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // planes at reset value: zero planes never reject
    send_volume(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_volume(mk_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 16'd0));
    drain();

    // x >= 0, x <= 100.0, z <= 100.0; remaining planes zero
    foreach (frustum[i]) frustum[i] = '0;
    frustum[REG_NEAR]   = '{d: 16'sd0, c: 16'sd0, b: 16'sd0, a: ONE_Q14};
    frustum[REG_FAR]    = '{d: FAR_D, c: 16'sd0, b: 16'sd0, a: NEG_ONE_Q14};
    frustum[REG_BOTTOM] = '{d: FAR_D, c: NEG_ONE_Q14, b: 16'sd0, a: 16'sd0};
    program_frustum(frustum);
    send_volume(mk_box(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_volume(mk_box(-16'sd10, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0));
    send_volume(mk_box(FAR_D, 16'sd0, 16'sd0, 16'sd1700, 16'sd0, 16'sd0));
    send_volume(mk_box(16'sd1601, 16'sd0, 16'sd0, 16'sd1700, 16'sd0, 16'sd0));
    send_volume(mk_box(16'sd100, 16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'sd0));
    send_volume(mk_box(-16'sd100, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0));
    send_volume(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_volume(mk_sphere(-16'sd16, 16'sd0, 16'sd0, 16'd16));
    send_volume(mk_sphere(-16'sd16, 16'sd0, 16'sd0, 16'd15));
    send_volume(mk_sphere(16'sd1616, 16'sd0, 16'sd0, 16'd16));
    send_volume(mk_sphere(COORD_MIN, 16'sd0, 16'sd0, 16'hFFFF));
    drain();

    foreach (frustum[i]) frustum[i] = {4{COORD_MIN}};
    program_frustum(frustum);
    send_volume(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_volume(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_volume(mk_sphere(16'sd0, 16'sd0, 16'sd0, 16'hFFFF));
    send_volume(mk_sphere(16'sd0, 16'sd0, 16'sd0, 16'd0));
    drain();

    foreach (frustum[i]) frustum[i] = {4{COORD_MAX}};
    program_frustum(frustum);
    send_volume(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_volume(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_volume(mk_sphere(COORD_MIN, COORD_MIN, COORD_MIN, 16'hFFFF));
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      foreach (frustum[i]) begin
        case (ph)
          1:       frustum[i] = {4{COORD_MIN}};
          2:       frustum[i] = {4{COORD_MAX}};
          3:       frustum[i] = '1;
          5:       frustum[i] = rand_plane(PLANE_RAW);
          4, 7:    frustum[i] = rand_plane($urandom_range(0, 1) ? PLANE_ZERO : PLANE_NORMAL);
          default: frustum[i] = rand_plane(PLANE_NORMAL);
        endcase
      end
      squeeze <= (ph == PRESSURE_PHASE);
      calm    <= (ph == RAND_PHASES - 1);
      program_frustum(frustum);
      repeat (ITEMS_PER_PHASE) send_volume(rand_volume());
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
